### hdl/ssiq_pkg.sv
// ssiq_pkg: sizes, codes and shared types of the stable sorted insert queue
// no dependencies; imported by every module of the queue
`default_nettype none

package ssiq_pkg;

    // storage geometry
    localparam int DEPTH        = 32;
    localparam int KEY_BITS     = 8;
    localparam int PAYLOAD_BITS = 16;

    // fixed port widths
    localparam int KIND_W    = 1;
    localparam int KEY_W     = 8;
    localparam int PAYLOAD_W = 16;
    localparam int STATUS_W  = 2;

    typedef logic [KEY_BITS-1:0]     t_key;
    typedef logic [PAYLOAD_BITS-1:0] t_payload;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 1'b0;
    localparam logic [KIND_W-1:0] KIND_DRAIN  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DROPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DRAINED  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd3;

    // operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_key     key;
        t_payload payload;
    } t_cell_ctl;

    // what a cell shows its neighbors
    typedef struct packed {
        logic     valid;
        logic     gt;
        t_key     key;
        t_payload payload;
    } t_cell_link;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

endpackage

`default_nettype wire

### hdl/ssiq_cell.sv
// ssiq_cell: one storage slot of the sorted chain
// depends on ssiq_pkg
`default_nettype none

module ssiq_cell
    import ssiq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_ctl  i_ctl,
    input  wire t_cell_link i_left,
    input  wire t_cell_link i_right,
    output t_cell_link      o_link
);

    logic     r_valid;
    t_key     r_key;
    t_payload r_payload;
    logic     n_valid;
    t_key     n_key;
    t_payload n_payload;
    logic     w_gt;
    logic     w_load;

    // stored key ranks after the new one: this slot moves right
    assign w_gt   = r_valid && (r_key > i_ctl.key);
    // slot takes data on an insert when it moves or is the first free one
    assign w_load = w_gt || (!r_valid && i_left.valid);

    // next slot contents
    always_comb begin
        n_valid   = r_valid;
        n_key     = r_key;
        n_payload = r_payload;
        case (i_ctl.op)
            OP_INSERT: begin
                if (w_load) begin
                    n_valid = 1'b1;
                    if (i_left.gt) begin
                        n_key     = i_left.key;
                        n_payload = i_left.payload;
                    end else begin
                        n_key     = i_ctl.key;
                        n_payload = i_ctl.payload;
                    end
                end
            end
            OP_SHIFT: begin
                n_valid   = i_right.valid;
                n_key     = i_right.key;
                n_payload = i_right.payload;
            end
            default: ;
        endcase
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // entry data
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
    end

    assign o_link.valid   = r_valid;
    assign o_link.gt      = w_gt;
    assign o_link.key     = r_key;
    assign o_link.payload = r_payload;

endmodule

`default_nettype wire

### hdl/ssiq_chain.sv
// ssiq_chain: row of DEPTH slots, each linked to both neighbors
// depends on ssiq_pkg and ssiq_cell
`default_nettype none

module ssiq_chain
    import ssiq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    output t_cell_link     o_head,
    output logic           o_second_valid,
    output logic           o_full
);

    t_cell_link w_link [DEPTH];
    t_cell_link w_edge_left;
    t_cell_link w_edge_right;

    // left end acts as a filled slot that never moves; right end is empty
    assign w_edge_left  = '{valid: 1'b1, gt: 1'b0, key: '0, payload: '0};
    assign w_edge_right = '{valid: 1'b0, gt: 1'b0, key: '0, payload: '0};

    // slot row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ssiq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_left  ((g == 0) ? w_edge_left : w_link[(g == 0) ? 0 : g - 1]),
            .i_right ((g == DEPTH - 1) ? w_edge_right
                                       : w_link[(g == DEPTH - 1) ? g : g + 1]),
            .o_link  (w_link[g])
        );
    end

    assign o_head         = w_link[0];
    assign o_second_valid = w_link[1].valid;
    assign o_full         = w_link[DEPTH-1].valid;

endmodule

`default_nettype wire

### hdl/stable_sorted_insert_queue.sv
// channel   | ports                                           | direction
// command   | i_start, o_busy, i_kind, i_sort_key, i_payload  | in
// result    | o_valid, o_status, o_out_key, o_out_payload,    | out
//           | o_last                                          |
//
// an insert leaves o_busy low; the next command is accepted in the cycle after
// a drain of n entries gives n results, one per cycle, set by the one-slot
// shift of the cell chain per cycle; o_busy is high while the entries after the first are shifted out
// every result is registered: it appears in the cycle after the one that produced it
// reset (synchronous, active low) empties the queue; no clearing pass
// the receiver cannot stall: each result stays for one cycle only
//
// top level of the stable sorted insert queue
// depends on ssiq_pkg and ssiq_chain
`default_nettype none

module stable_sorted_insert_queue
    import ssiq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire logic [KIND_W-1:0]    i_kind,
    input  wire logic [KEY_W-1:0]     i_sort_key,
    input  wire logic [PAYLOAD_W-1:0] i_payload,
    output logic                      o_valid,
    output logic [STATUS_W-1:0]       o_status,
    output logic [KEY_W-1:0]          o_out_key,
    output logic [PAYLOAD_W-1:0]      o_out_payload,
    output logic                      o_last
);

    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [KEY_W-1:0]     r_key, n_key;
    logic [PAYLOAD_W-1:0] r_payload, n_payload;
    logic       r_last, n_last;
    logic       w_accept;
    t_cell_ctl  w_ctl;
    t_cell_link w_head;
    logic       w_second_valid;
    logic       w_full;

    assign o_busy   = (r_state == ST_DRAIN);
    assign w_accept = i_start && !o_busy;

    ssiq_chain u_chain (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .o_head         (w_head),
        .o_second_valid (w_second_valid),
        .o_full         (w_full)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_key     <= n_key;
        r_payload <= n_payload;
        r_last    <= n_last;
    end

    // next state, chain command and next result
    always_comb begin
        n_state       = r_state;
        n_out_valid   = 1'b0;
        n_status      = STAT_INSERTED;
        n_key         = '0;
        n_payload     = '0;
        n_last        = 1'b1;
        w_ctl.op      = OP_HOLD;
        w_ctl.key     = t_key'(i_sort_key);
        w_ctl.payload = t_payload'(i_payload);
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    if (i_kind == KIND_INSERT) begin
                        if (w_full) begin
                            n_status = STAT_DROPPED;
                        end else begin
                            w_ctl.op = OP_INSERT;
                            n_status = STAT_INSERTED;
                        end
                    end else if (!w_head.valid) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        w_ctl.op  = OP_SHIFT;
                        n_status  = STAT_DRAINED;
                        n_key     = KEY_W'(w_head.key);
                        n_payload = PAYLOAD_W'(w_head.payload);
                        n_last    = !w_second_valid;
                        if (w_second_valid) begin
                            n_state = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                w_ctl.op    = OP_SHIFT;
                n_out_valid = 1'b1;
                n_status    = STAT_DRAINED;
                n_key       = KEY_W'(w_head.key);
                n_payload   = PAYLOAD_W'(w_head.payload);
                n_last      = !w_second_valid;
                if (!w_second_valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_out_key     = r_key;
    assign o_out_payload = r_payload;
    assign o_last        = r_last;

    // a drain in progress always has an entry at the head
    a_drain_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> w_head.valid)
        else $error("drain running with empty head slot");

    // draining the final entry returns to idle
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN && !w_second_valid) |=> (r_state == ST_IDLE))
        else $error("drain did not end after final entry");

    // only drained entries may continue a transaction
    a_single_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STAT_DRAINED) |-> o_last)
        else $error("non-drain result without last flag");

    // a dropped insert leaves the full queue unchanged
    a_drop_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_kind == KIND_INSERT && w_full) |=> w_full)
        else $error("queue changed on dropped insert");

endmodule

`default_nettype wire

### tb/tb_stable_sorted_insert_queue.sv
// tb_stable_sorted_insert_queue: self-checking testbench of the stable sorted insert queue
// predicts each status and drained entry from a local copy of the queue and checks them
// depends on ssiq_pkg and stable_sorted_insert_queue
`timescale 1ns / 100ps

module tb_stable_sorted_insert_queue;
    import ssiq_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_ITEMS = 160;
    localparam int CYCLE_LIMIT  = 200000;

    // one result transaction as the receiver sees it
    typedef struct {
        logic [STATUS_W-1:0]  status;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic                 last;
    } t_queue_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [KIND_W-1:0]    i_kind;
    logic [KEY_W-1:0]     i_sort_key;
    logic [PAYLOAD_W-1:0] i_payload;
    logic                 o_valid;
    logic [STATUS_W-1:0]  o_status;
    logic [KEY_W-1:0]     o_out_key;
    logic [PAYLOAD_W-1:0] o_out_payload;
    logic                 o_last;

    // local copy of the sorted store
    t_key          sorted_keys[DEPTH];
    t_payload      sorted_payloads[DEPTH];
    int            sorted_count;
    t_queue_result expected_results[$];

    bit idle_enable;
    int items_sent;
    int inserts_kept;
    int inserts_dropped;
    int drains_done;
    int results_checked = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    stable_sorted_insert_queue DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_kind        (i_kind),
        .i_sort_key    (i_sort_key),
        .i_payload     (i_payload),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_out_key     (o_out_key),
        .o_out_payload (o_out_payload),
        .o_last        (o_last)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // run length guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_queue_result make_result(logic [STATUS_W-1:0] status,
                                                  t_key key, t_payload payload,
                                                  logic last);
        t_queue_result r;
        r.status  = status;
        r.key     = key;
        r.payload = payload;
        r.last    = last;
        return r;
    endfunction

    // sorted store update and expected results for one accepted command
    task automatic predict_command(logic [KIND_W-1:0] kind, t_key key, t_payload payload);
        int pos;
        if (kind == KIND_INSERT) begin
            if (sorted_count >= DEPTH) begin
                expected_results.push_back(make_result(STAT_DROPPED, '0, '0, 1'b1));
                inserts_dropped++;
            end else begin
                // after every entry with a key less than or equal, so ties keep arrival order
                pos = 0;
                while (pos < sorted_count && sorted_keys[pos] <= key)
                    pos++;
                for (int i = sorted_count; i > pos; i--) begin
                    sorted_keys[i]     = sorted_keys[i-1];
                    sorted_payloads[i] = sorted_payloads[i-1];
                end
                sorted_keys[pos]     = key;
                sorted_payloads[pos] = payload;
                sorted_count++;
                expected_results.push_back(make_result(STAT_INSERTED, '0, '0, 1'b1));
                inserts_kept++;
            end
        end else begin
            if (sorted_count == 0) begin
                expected_results.push_back(make_result(STAT_EMPTY, '0, '0, 1'b1));
            end else begin
                for (int i = 0; i < sorted_count; i++)
                    expected_results.push_back(make_result(STAT_DRAINED, sorted_keys[i],
                                                           sorted_payloads[i],
                                                           (i == sorted_count - 1)));
            end
            sorted_count = 0;
            drains_done++;
        end
    endtask

    // one command transaction; entered and left just after a falling edge
    task automatic send_command(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                logic [PAYLOAD_W-1:0] payload);
        int gap;
        gap = 0;
        if (idle_enable && $urandom_range(0, 99) < 25)
            gap = $urandom_range(1, 2);
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start    = 1'b1;
        i_kind     = kind;
        i_sort_key = key;
        i_payload  = payload;
        // busy read here still holds its value from before the edge
        do
            @(posedge i_clk);
        while (o_busy);
        predict_command(kind, t_key'(key), t_payload'(payload));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // result checker: every strobe is compared with the oldest expectation
    always @(posedge i_clk) begin
        t_queue_result exp_r;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result status %0d key 0x%0h payload 0x%0h last %0b",
                         $time, o_status, o_out_key, o_out_payload, o_last);
                mismatch_count++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("status", exp_r.status, o_status);
                check_field("out_key", exp_r.key, o_out_key);
                check_field("out_payload", exp_r.payload, o_out_payload);
                check_field("last", exp_r.last, o_last);
                results_checked++;
            end
        end
    end

    // drains of an empty store, from reset and back to back
    task automatic test_empty_drain();
        send_command(KIND_DRAIN, 8'h00, 16'h0000);
        send_command(KIND_DRAIN, 8'hFF, 16'hFFFF);
    endtask

    // key extremes, ties, payload extremes and a single-entry drain
    task automatic test_ordering();
        send_command(KIND_INSERT, 8'd128, 16'hAAAA);
        send_command(KIND_INSERT, 8'd255, 16'hFFFF);
        send_command(KIND_INSERT, 8'd0,   16'h0000);
        send_command(KIND_INSERT, 8'd128, 16'h5555);
        send_command(KIND_INSERT, 8'd0,   16'h1234);
        send_command(KIND_INSERT, 8'd128, 16'h0001);
        send_command(KIND_INSERT, 8'd255, 16'h8000);
        send_command(KIND_INSERT, 8'd1,   16'h7FFF);
        send_command(KIND_INSERT, 8'd254, 16'hFFFE);
        send_command(KIND_DRAIN,  8'h00,  16'h0000);
        send_command(KIND_INSERT, 8'd77,  16'hBEEF);
        send_command(KIND_DRAIN,  8'h55,  16'h5A5A);
    endtask

    // fill to capacity, overflow twice, drain, then reuse the emptied store
    task automatic test_full_store();
        for (int i = 0; i < DEPTH; i++)
            send_command(KIND_INSERT, KEY_W'($urandom_range(0, 7)),
                         PAYLOAD_W'($urandom_range(0, 65535)));
        send_command(KIND_INSERT, 8'd0,   16'hDEAD);
        send_command(KIND_INSERT, 8'd255, 16'hFFFF);
        send_command(KIND_DRAIN,  8'h00,  16'h0000);
        send_command(KIND_INSERT, 8'd3,   16'h0F0F);
        send_command(KIND_DRAIN,  8'h00,  16'h0000);
    endtask

    // insert bursts with random content, each closed by a drain
    task automatic test_random_traffic(int n_items);
        int start_count;
        int burst;
        bit narrow_keys;
        start_count = items_sent;
        while (items_sent - start_count < n_items) begin
            if ($urandom_range(0, 9) == 0)
                burst = $urandom_range(DEPTH - 2, DEPTH + 3);
            else
                burst = $urandom_range(0, 12);
            narrow_keys = $urandom_range(0, 1);
            for (int b = 0; b < burst; b++) begin
                // no idling in the middle of the run
                idle_enable = !((items_sent - start_count) >= n_items / 3 &&
                                (items_sent - start_count) < n_items / 3 + 60);
                send_command(KIND_INSERT,
                             narrow_keys ? KEY_W'($urandom_range(0, 3))
                                         : KEY_W'($urandom_range(0, 255)),
                             PAYLOAD_W'($urandom_range(0, 65535)));
            end
            send_command(KIND_DRAIN, KEY_W'($urandom_range(0, 255)),
                         PAYLOAD_W'($urandom_range(0, 65535)));
        end
    endtask

    // sequence of tests and the final verdict
    initial begin
        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_kind          = KIND_INSERT;
        i_sort_key      = '0;
        i_payload       = '0;
        idle_enable     = 1'b1;
        sorted_count    = 0;
        items_sent      = 0;
        inserts_kept    = 0;
        inserts_dropped = 0;
        drains_done     = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_drain();
        test_ordering();
        test_full_store();
        test_random_traffic(RANDOM_ITEMS);
        i_start = 1'b0;

        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DEPTH + 4) @(posedge i_clk);

        $display("covered %0d commands: %0d inserts kept, %0d dropped on a full store,",
                 items_sent, inserts_kept, inserts_dropped);
        $display("%0d drains, %0d results checked, %0d mismatches",
                 drains_done, results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
